>>> src/ptpq_pkg.sv
`default_nettype none
package ptpq_pkg;

  typedef struct packed {
    logic [31:0] expiry;
    logic        repeat_en;
    logic [31:0] period;
  } entry_t;

  localparam int OpW = 5;
  typedef logic [OpW-1:0] op_t;

  localparam op_t OP_NONE       = 5'd0;
  localparam op_t OP_LOAD       = 5'd1;
  localparam op_t OP_PUSH_START = 5'd2;
  localparam op_t OP_WR_ITEM    = 5'd3;
  localparam op_t OP_RD_PARENT  = 5'd4;
  localparam op_t OP_WR_PARENT  = 5'd5;
  localparam op_t OP_POP_START  = 5'd6;
  localparam op_t OP_RD_LAST    = 5'd7;
  localparam op_t OP_LOAD_Q     = 5'd8;
  localparam op_t OP_RD_LEFT    = 5'd9;
  localparam op_t OP_CAP_LEFT   = 5'd10;
  localparam op_t OP_CAP_RIGHT  = 5'd11;
  localparam op_t OP_WR_CHILD   = 5'd12;
  localparam op_t OP_RD_ROOT    = 5'd13;
  localparam op_t OP_CHECK      = 5'd14;
  localparam op_t OP_ADVANCE    = 5'd15;
  localparam op_t OP_EMIT       = 5'd16;
  localparam op_t OP_DROP       = 5'd17;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic full;
    logic i_zero;
    logic lt_parent;
    logic size_zero;
    logic has_left;
    logic has_right;
    logic cmove;
    logic due;
    logic rep;
    logic lt_now;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

>>> src/ptpq_ram.sv
`default_nettype none
module ptpq_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/ptpq_ctrl.sv
`default_nettype none
module ptpq_ctrl
  import ptpq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_UP    = 4'd2;
  localparam logic [3:0] S_UPCHK = 4'd3;
  localparam logic [3:0] S_TCHK  = 4'd4;
  localparam logic [3:0] S_ADV   = 4'd5;
  localparam logic [3:0] S_P0    = 4'd6;
  localparam logic [3:0] S_PCHK  = 4'd7;
  localparam logic [3:0] S_PLAST = 4'd8;
  localparam logic [3:0] S_PLD   = 4'd9;
  localparam logic [3:0] S_DN    = 4'd10;
  localparam logic [3:0] S_DNL   = 4'd11;
  localparam logic [3:0] S_DNR   = 4'd12;
  localparam logic [3:0] S_DNDEC = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (st.func) begin
          if (st.full) begin
            cmd.op     = OP_DROP;
            state_next = S_FIN;
          end else begin
            cmd.op     = OP_PUSH_START;
            state_next = S_UP;
          end
        end else if (st.size_zero) begin
          state_next = S_ADV;
        end else begin
          cmd.op     = OP_RD_ROOT;
          state_next = S_TCHK;
        end
      end
      S_UP: begin
        if (st.i_zero) begin
          cmd.op     = OP_WR_ITEM;
          state_next = st.func ? S_FIN : S_ADV;
        end else begin
          cmd.op     = OP_RD_PARENT;
          state_next = S_UPCHK;
        end
      end
      S_UPCHK: begin
        if (st.lt_parent) begin
          cmd.op     = OP_WR_PARENT;
          state_next = S_UP;
        end else begin
          cmd.op     = OP_WR_ITEM;
          state_next = st.func ? S_FIN : S_ADV;
        end
      end
      S_TCHK: begin
        if (st.due) begin
          cmd.op     = OP_CHECK;
          state_next = (st.rep && !st.full) ? S_UP : S_ADV;
        end else begin
          state_next = S_ADV;
        end
      end
      S_ADV: begin
        cmd.op     = OP_ADVANCE;
        state_next = S_P0;
      end
      S_P0: begin
        if (st.size_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.op     = OP_RD_ROOT;
          state_next = S_PCHK;
        end
      end
      S_PCHK: begin
        if (st.lt_now) begin
          cmd.op     = OP_POP_START;
          state_next = S_PLAST;
        end else begin
          state_next = S_FIN;
        end
      end
      S_PLAST: begin
        if (st.size_zero) begin
          state_next = S_P0;
        end else begin
          cmd.op     = OP_RD_LAST;
          state_next = S_PLD;
        end
      end
      S_PLD: begin
        cmd.op     = OP_LOAD_Q;
        state_next = S_DN;
      end
      S_DN: begin
        if (st.has_left) begin
          cmd.op     = OP_RD_LEFT;
          state_next = S_DNL;
        end else begin
          cmd.op     = OP_WR_ITEM;
          state_next = S_P0;
        end
      end
      S_DNL: begin
        cmd.op     = OP_CAP_LEFT;
        state_next = st.has_right ? S_DNR : S_DNDEC;
      end
      S_DNR: begin
        cmd.op     = OP_CAP_RIGHT;
        state_next = S_DNDEC;
      end
      S_DNDEC: begin
        if (st.cmove) begin
          cmd.op     = OP_WR_CHILD;
          state_next = S_DN;
        end else begin
          cmd.op     = OP_WR_ITEM;
          state_next = S_P0;
        end
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> src/ptpq_dp.sv
`default_nettype none
module ptpq_dp
  import ptpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          st,
  input  wire logic        cfg_write_en,
  input  wire logic [31:0] cfg_write_data,
  input  wire logic        func,
  input  wire logic [31:0] timer_time,
  input  wire logic        timer_repeat,
  input  wire logic [31:0] timer_period,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             alarm,
  output logic             rearmed,
  output logic [31:0]      clock_now,
  output logic [4:0]       pending_count,
  output logic             insert_dropped
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int XW = IW + 2;
  localparam int EW = $bits(entry_t);

  logic [31:0]   now;
  logic [CW-1:0] size;
  logic [IW-1:0] idx;
  logic [IW-1:0] cidx;
  entry_t        item;
  entry_t        child;
  logic          cmove;
  logic          func_r;
  logic          alarm_r, rearm_r, drop_r;

  entry_t        q;
  logic [EW-1:0] rdata;
  logic          we;
  logic [IW-1:0] waddr, raddr;
  entry_t        wdata;

  logic [XW-1:0] lidx, ridx, size_x;
  logic [IW-1:0] pidx;
  logic [31:0]   best_exp;

  assign q      = entry_t'(rdata);
  assign size_x = XW'(size);
  assign lidx   = (XW'(idx) << 1) + XW'(1);
  assign ridx   = lidx + XW'(1);
  assign pidx   = (idx - IW'(1)) >> 1;
  assign best_exp = cmove ? child.expiry : item.expiry;

  always_comb begin
    st.func      = func_r;
    st.full      = (size == CW'(QUEUE_DEPTH));
    st.i_zero    = (idx == '0);
    st.lt_parent = (item.expiry < q.expiry);
    st.size_zero = (size == '0);
    st.has_left  = (lidx < size_x);
    st.has_right = (ridx < size_x);
    st.cmove     = cmove;
    st.due       = (q.expiry <= now);
    st.rep       = q.repeat_en;
    st.lt_now    = (q.expiry < now);
    st.out_busy  = out_valid && !out_ready;
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = item;
    raddr = '0;
    unique case (cmd.op)
      OP_WR_ITEM: begin
        we = 1'b1;
      end
      OP_WR_PARENT: begin
        we    = 1'b1;
        wdata = q;
      end
      OP_WR_CHILD: begin
        we    = 1'b1;
        wdata = child;
      end
      OP_RD_PARENT: raddr = pidx;
      OP_RD_LAST:   raddr = size[IW-1:0];
      OP_RD_LEFT:   raddr = lidx[IW-1:0];
      OP_CAP_LEFT:  raddr = ridx[IW-1:0];
      default: begin
      end
    endcase
  end

  ptpq_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      now       <= '0;
      size      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write_en) begin
        now <= cfg_write_data;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          func_r  <= func;
          item    <= '{expiry: timer_time, repeat_en: timer_repeat, period: timer_period};
          alarm_r <= 1'b0;
          rearm_r <= 1'b0;
          drop_r  <= 1'b0;
        end
        OP_PUSH_START: begin
          idx  <= size[IW-1:0];
          size <= size + CW'(1);
        end
        OP_WR_PARENT: idx <= pidx;
        OP_POP_START: size <= size - CW'(1);
        OP_RD_LAST:   idx <= '0;
        OP_LOAD_Q:    item <= q;
        OP_CAP_LEFT: begin
          child <= q;
          cidx  <= lidx[IW-1:0];
          cmove <= (q.expiry < item.expiry);
        end
        OP_CAP_RIGHT: begin
          if (q.expiry < best_exp) begin
            child <= q;
            cidx  <= ridx[IW-1:0];
            cmove <= 1'b1;
          end
        end
        OP_WR_CHILD: idx <= cidx;
        OP_CHECK: begin
          alarm_r <= (q.expiry == now);
          if (q.repeat_en) begin
            if (st.full) begin
              drop_r <= 1'b1;
            end else begin
              rearm_r <= 1'b1;
              item    <= '{expiry: now + q.period, repeat_en: 1'b1, period: q.period};
              idx     <= size[IW-1:0];
              size    <= size + CW'(1);
            end
          end
        end
        OP_ADVANCE: now <= now + 32'd1;
        OP_DROP:    drop_r <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      alarm          <= alarm_r;
      rearmed        <= rearm_r;
      clock_now      <= now;
      pending_count  <= 5'(size);
      insert_dropped <= drop_r;
    end
  end

endmodule
`default_nettype wire

>>> src/periodic_timer_priority_queue.sv
`default_nettype none
// Channel   Handshake              Payload
// request   in_valid / in_ready    func, timer_time, timer_repeat, timer_period
// result    out_valid / out_ready  alarm, rearmed, clock_now, pending_count, insert_dropped
// config    cfg_write_en           cfg_write_data (start_time, loads the clock)
//
// One request at a time; the heap sits in a single-port-read RAM, one access per step.
// Insert: a sift up from the new last slot, or a drop when the heap is full.
// Tick: root check, sift up on re-arm, clock advance, then a sift down per popped timer.
// Sync reset clears clock and count; heap RAM is not cleared.
// A held result stalls the next one in the finish state; requests wait on in_ready.
module periodic_timer_priority_queue
  import ptpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [31:0] cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [31:0] timer_time,
  input  wire logic        timer_repeat,
  input  wire logic [31:0] timer_period,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             alarm,
  output logic             rearmed,
  output logic [31:0]      clock_now,
  output logic [4:0]       pending_count,
  output logic             insert_dropped
);

  cmd_t    cmd;
  status_t st;

  ptpq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  ptpq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .func          (func),
    .timer_time    (timer_time),
    .timer_repeat  (timer_repeat),
    .timer_period  (timer_period),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .alarm         (alarm),
    .rearmed       (rearmed),
    .clock_now     (clock_now),
    .pending_count (pending_count),
    .insert_dropped(insert_dropped)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_drop_not_rearm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(insert_dropped && rearmed))
    else $error("drop and re-arm together");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (QUEUE_DEPTH > 31 || int'(pending_count) <= QUEUE_DEPTH))
    else $error("count above depth");

endmodule
`default_nettype wire
